/* rtl/cdpd_pkg.sv */
// Shared types, constants and helpers for the double pendulum derivative pipeline.
// Used by cdpd_fmul, compound_double_pendulum_derivative and the testbench; depends on nothing.
package cdpd_pkg;

    localparam int ANGLE_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int NUM_REGS = 5;
    localparam int CFG_AW   = 3;
    localparam logic [CFG_AW-1:0] REG_INERTIA_FIRST  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_INERTIA_SECOND = 3'd1;
    localparam logic [CFG_AW-1:0] REG_COUPLING       = 3'd2;
    localparam logic [CFG_AW-1:0] REG_GRAVITY_FIRST  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_GRAVITY_SECOND = 3'd4;

    localparam logic signed [31:0] INERTIA_FIRST_RST  = 32'sd65536;
    localparam logic signed [31:0] INERTIA_SECOND_RST = 32'sd65536;
    localparam logic signed [31:0] COUPLING_RST       = 32'sd32768;
    localparam logic signed [31:0] GRAVITY_FIRST_RST  = 32'sd65536;
    localparam logic signed [31:0] GRAVITY_SECOND_RST = 32'sd65536;

    typedef logic signed [63:0] val_t;
    typedef logic signed [31:0] trig_t;

    localparam val_t        LIM      = 64'sh0FFF_FFFF_FFFF_FFFF;
    localparam logic [59:0] LIM_MAG  = '1;
    localparam logic [31:0] QUARTER  = 32'h4000_0000;
    localparam logic [30:0] Q30      = 31'h4000_0000;

    localparam logic [30:0] C1 = 31'd1686629713;
    localparam logic [30:0] C3 = 31'd693598668;
    localparam logic [30:0] C5 = 31'd85569306;
    localparam logic [30:0] C7 = 31'd5026995;
    localparam logic [30:0] C9 = 31'd172272;
    localparam logic [30:0] HORNER_C [4] = '{C7, C5, C3, C1};

    typedef struct packed {
        logic ovf;
        val_t v;
    } clamp_t;

    function automatic clamp_t clamp_val(input val_t v);
        clamp_t r;
        r.ovf = 1'b0;
        r.v   = v;
        if (v > LIM) begin
            r.ovf = 1'b1;
            r.v   = LIM;
        end else if (v < -LIM) begin
            r.ovf = 1'b1;
            r.v   = -LIM;
        end
        return r;
    endfunction

endpackage

/* rtl/cdpd_fmul.sv */
// Three-stage signed fixed-point multiplier with truncating shift and clamp.
// Depends on cdpd_pkg.
module cdpd_fmul
    import cdpd_pkg::*;
#(
    parameter int SH = FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic en,
    input  val_t a,
    input  val_t b,
    output val_t p,
    output logic ovf
);

    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [63:0]  p0_reg, p1_reg, p2_reg, p3_reg;
    logic         neg1_reg, neg2_reg;
    logic [127:0] prod_reg;
    logic [127:0] shifted;
    logic         big;
    logic [59:0]  mag;
    val_t         p_next;
    val_t         p_reg;
    logic         ovf_reg;

    always_comb begin
        ua      = a[63] ? 64'(-a) : 64'(a);
        ub      = b[63] ? 64'(-b) : 64'(b);
        shifted = prod_reg >> SH;
        big     = |shifted[127:60];
        mag     = big ? LIM_MAG : shifted[59:0];
        p_next  = neg2_reg ? -val_t'(mag) : val_t'(mag);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_reg   <= 64'(ua[31:0]) * 64'(ub[31:0]);
            p1_reg   <= 64'(ua[31:0]) * 64'(ub[63:32]);
            p2_reg   <= 64'(ua[63:32]) * 64'(ub[31:0]);
            p3_reg   <= 64'(ua[63:32]) * 64'(ub[63:32]);
            neg1_reg <= a[63] ^ b[63];
            prod_reg <= {64'd0, p0_reg} + {32'd0, p1_reg, 32'd0}
                      + {32'd0, p2_reg, 32'd0} + {p3_reg, 64'd0};
            neg2_reg <= neg1_reg;
            p_reg    <= p_next;
            ovf_reg  <= big;
        end
    end

    assign p   = p_reg;
    assign ovf = ovf_reg;

endmodule

/* rtl/compound_double_pendulum_derivative.sv */
// Double pendulum derivative pipeline: trig lanes, multiplier tree, restoring divider.
// Depends on cdpd_pkg and cdpd_fmul.
// The block takes one state per clock whenever the output is not held and returns its
// derivative after the sine and product stages and the 32-stage restoring divider,
// which yields one quotient bit per stage. When the output register is held, the whole
// pipeline holds with it, so nothing is lost or repeated.
module compound_double_pendulum_derivative
    import cdpd_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // angle_first, rate_first, angle_second, rate_second
    input  logic [127:0]        s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // angle_rate_first, accel_first, angle_rate_second, accel_second
    output logic [127:0]        m_tdata,
    // saturated
    output logic [0:0]          m_tuser,
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [31:0]         cfg_wdata
);

    localparam int DIV_BITS = 32;
    localparam int DIV_RW   = 62 + DIV_BITS;
    localparam int LAST     = 50;
    localparam int N_A = 10;
    localparam int N_B = 4;
    localparam int N_C = 9;
    localparam int N_D = 5;

    logic adv;
    logic vld_reg [0:LAST];

    logic signed [31:0] inertia_first_reg, inertia_second_reg, coupling_reg;
    logic signed [31:0] gravity_first_reg, gravity_second_reg;
    val_t c0, c1, c2, c3, c4;

    logic [31:0] a1_next, a2_next;
    logic [31:0] ang_reg [4];
    logic signed [31:0] w_reg [0:49][2];
    trig_t trig [4];

    val_t fa_a [N_A], fb_a [N_A], fp_a [N_A];
    val_t fa_b [N_B], fb_b [N_B], fp_b [N_B];
    val_t fa_c [N_C], fb_c [N_C], fp_c [N_C];
    val_t fa_d [N_D], fb_d [N_D], fp_d [N_D];
    logic [N_A-1:0] fo_a;
    logic [N_B-1:0] fo_b;
    logic [N_C-1:0] fo_c;
    logic [N_D-1:0] fo_d;

    val_t  hold_a_reg [4][5];
    val_t  hold_b_reg [4];
    trig_t trig_dly_reg [3][3];
    val_t  d4_reg [0:9];
    val_t  dbl_reg [4];
    val_t  dbl_dly_reg [3][4];
    val_t  tu4_reg [2][2];
    val_t  n1a_reg, n2a_reg, den1_reg;
    val_t  n1b_reg, n2b_reg, den2_reg;
    val_t  num_reg [2];
    val_t  den_reg;

    clamp_t d4_c;
    clamp_t dbl_c [4];
    clamp_t n1a_c, n2a_c, den1_c, n1b_c, n2b_c, n1_c, n2_c;
    logic [48:3] fin;
    logic fl_reg [4:49];

    logic [60:0]       ud_reg [0:DIV_BITS];
    logic              dz_reg [0:DIV_BITS];
    logic [DIV_RW-1:0] r_reg   [2][0:DIV_BITS];
    logic [31:0]       q_reg   [2][0:DIV_BITS];
    logic              neg_reg [2][0:DIV_BITS];
    logic              big_reg [2][0:DIV_BITS];
    logic              npos_reg[2][0:DIV_BITS];
    logic              nneg_reg[2][0:DIV_BITS];
    logic [60:0]       ud_next;
    logic [31:0]       acc_next [2];
    logic              sat_next [2];

    logic signed [31:0] m_w1_reg, m_w2_reg;
    logic [31:0]        m_acc1_reg, m_acc2_reg;
    logic               m_sat_reg;

    assign adv      = !vld_reg[LAST] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAST];
    assign m_tdata  = {m_acc2_reg, m_w2_reg, m_acc1_reg, m_w1_reg};
    assign m_tuser  = m_sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inertia_first_reg  <= INERTIA_FIRST_RST;
            inertia_second_reg <= INERTIA_SECOND_RST;
            coupling_reg       <= COUPLING_RST;
            gravity_first_reg  <= GRAVITY_FIRST_RST;
            gravity_second_reg <= GRAVITY_SECOND_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_INERTIA_FIRST:  inertia_first_reg  <= cfg_wdata;
                REG_INERTIA_SECOND: inertia_second_reg <= cfg_wdata;
                REG_COUPLING:       coupling_reg       <= cfg_wdata;
                REG_GRAVITY_FIRST:  gravity_first_reg  <= cfg_wdata;
                REG_GRAVITY_SECOND: gravity_second_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        c0 = val_t'(inertia_first_reg);
        c1 = val_t'(inertia_second_reg);
        c2 = val_t'(coupling_reg);
        c3 = val_t'(gravity_first_reg);
        c4 = val_t'(gravity_second_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= LAST; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k <= LAST; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_comb begin
        a1_next = 32'(s_tdata[31:0] << (32 - ANGLE_BITS));
        a2_next = 32'(s_tdata[95:64] << (32 - ANGLE_BITS));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ang_reg[0] <= a1_next;
            ang_reg[1] <= a2_next;
            ang_reg[2] <= a1_next - a2_next;
            ang_reg[3] <= a1_next - a2_next + QUARTER;
            w_reg[0][0] <= s_tdata[63:32];
            w_reg[0][1] <= s_tdata[127:96];
            for (int k = 1; k < 50; k++) begin
                w_reg[k] <= w_reg[k-1];
            end
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_trig
        logic [30:0] x_reg   [1:6];
        logic        neg_reg [1:6];
        logic [30:0] sq_reg  [2:5];
        logic [30:0] p_reg   [3:6];
        trig_t       s_reg;
        logic [30:0] x_next;
        logic [61:0] sq_prod;
        logic [61:0] h_prod [3:6];
        logic [61:0] s_prod;

        always_comb begin
            x_next = ang_reg[l][30] ? (Q30 - 31'(ang_reg[l][29:0])) : 31'(ang_reg[l][29:0]);
            sq_prod = 62'(x_reg[1]) * 62'(x_reg[1]);
            h_prod[3] = 62'(sq_reg[2]) * 62'(C9);
            for (int k = 4; k <= 6; k++) begin
                h_prod[k] = 62'(sq_reg[k-1]) * 62'(p_reg[k-1]);
            end
            s_prod = 62'(x_reg[6]) * 62'(p_reg[6]);
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                x_reg[1]   <= x_next;
                neg_reg[1] <= ang_reg[l][31];
                for (int k = 2; k <= 6; k++) begin
                    x_reg[k]   <= x_reg[k-1];
                    neg_reg[k] <= neg_reg[k-1];
                end
                sq_reg[2] <= sq_prod[60:30];
                for (int k = 3; k <= 5; k++) begin
                    sq_reg[k] <= sq_reg[k-1];
                end
                for (int k = 3; k <= 6; k++) begin
                    p_reg[k] <= HORNER_C[k-3] - h_prod[k][60:30];
                end
                s_reg <= neg_reg[6] ? -trig_t'(s_prod[60:30]) : trig_t'(s_prod[60:30]);
            end
        end

        assign trig[l] = s_reg;
    end

    always_comb begin
        fa_a[0] = c2;                 fb_a[0] = c2;
        fa_a[1] = val_t'(w_reg[0][0]); fb_a[1] = val_t'(w_reg[0][0]);
        fa_a[2] = val_t'(w_reg[0][1]); fb_a[2] = val_t'(w_reg[0][1]);
        fa_a[3] = c1;                 fb_a[3] = c3;
        fa_a[4] = c1;                 fb_a[4] = c2;
        fa_a[5] = c2;                 fb_a[5] = c4;
        fa_a[6] = c0;                 fb_a[6] = c4;
        fa_a[7] = c0;                 fb_a[7] = c2;
        fa_a[8] = c2;                 fb_a[8] = c3;
        fa_a[9] = c0;                 fb_a[9] = c1;

        fa_b[0] = fp_a[0]; fb_b[0] = fp_a[1];
        fa_b[1] = fp_a[0]; fb_b[1] = fp_a[2];
        fa_b[2] = fp_a[4]; fb_b[2] = fp_a[2];
        fa_b[3] = fp_a[7]; fb_b[3] = fp_a[1];

        fa_c[0] = hold_a_reg[3][0]; fb_c[0] = val_t'(trig[0]);
        fa_c[1] = hold_b_reg[0];    fb_c[1] = val_t'(trig[2]);
        fa_c[2] = hold_b_reg[2];    fb_c[2] = val_t'(trig[2]);
        fa_c[3] = hold_a_reg[3][1]; fb_c[3] = val_t'(trig[3]);
        fa_c[4] = hold_a_reg[3][2]; fb_c[4] = val_t'(trig[1]);
        fa_c[5] = hold_b_reg[1];    fb_c[5] = val_t'(trig[2]);
        fa_c[6] = hold_b_reg[3];    fb_c[6] = val_t'(trig[2]);
        fa_c[7] = hold_a_reg[3][3]; fb_c[7] = val_t'(trig[3]);
        fa_c[8] = hold_a_reg[3][4]; fb_c[8] = val_t'(trig[3]);

        fa_d[0] = fp_c[1]; fb_d[0] = val_t'(trig_dly_reg[2][2]);
        fa_d[1] = fp_c[3]; fb_d[1] = val_t'(trig_dly_reg[2][1]);
        fa_d[2] = fp_c[5]; fb_d[2] = val_t'(trig_dly_reg[2][2]);
        fa_d[3] = fp_c[7]; fb_d[3] = val_t'(trig_dly_reg[2][0]);
        fa_d[4] = fp_c[8]; fb_d[4] = val_t'(trig_dly_reg[2][2]);
    end

    for (genvar i = 0; i < N_A; i++) begin : g_mul_a
        cdpd_fmul #(.SH(FRAC_BITS)) u_mul (
            .aclk(aclk), .en(adv), .a(fa_a[i]), .b(fb_a[i]), .p(fp_a[i]), .ovf(fo_a[i])
        );
    end
    for (genvar i = 0; i < N_B; i++) begin : g_mul_b
        cdpd_fmul #(.SH(FRAC_BITS)) u_mul (
            .aclk(aclk), .en(adv), .a(fa_b[i]), .b(fb_b[i]), .p(fp_b[i]), .ovf(fo_b[i])
        );
    end
    for (genvar i = 0; i < N_C; i++) begin : g_mul_c
        cdpd_fmul #(.SH(30)) u_mul (
            .aclk(aclk), .en(adv), .a(fa_c[i]), .b(fb_c[i]), .p(fp_c[i]), .ovf(fo_c[i])
        );
    end
    for (genvar i = 0; i < N_D; i++) begin : g_mul_d
        cdpd_fmul #(.SH(30)) u_mul (
            .aclk(aclk), .en(adv), .a(fa_d[i]), .b(fb_d[i]), .p(fp_d[i]), .ovf(fo_d[i])
        );
    end

    always_comb begin
        d4_c     = clamp_val(fp_a[9] <<< 2);
        dbl_c[0] = clamp_val(fp_c[0] <<< 1);
        dbl_c[1] = clamp_val(fp_c[2] <<< 1);
        dbl_c[2] = clamp_val(fp_c[4] <<< 1);
        dbl_c[3] = clamp_val(fp_c[6] <<< 1);
        n1a_c    = clamp_val(dbl_dly_reg[1][0] + fp_d[0]);
        n2a_c    = clamp_val(dbl_dly_reg[1][2] - fp_d[2]);
        den1_c   = clamp_val(fp_d[4] - d4_reg[9]);
        n1b_c    = clamp_val(n1a_reg + dbl_dly_reg[2][1]);
        n2b_c    = clamp_val(n2a_reg - dbl_dly_reg[2][3]);
        n1_c     = clamp_val(n1b_reg - tu4_reg[1][0]);
        n2_c     = clamp_val(n2b_reg - tu4_reg[1][1]);

        fin     = '0;
        fin[3]  = |fo_a | d4_c.ovf;
        fin[6]  = |fo_b;
        fin[10] = |fo_c | dbl_c[0].ovf | dbl_c[1].ovf | dbl_c[2].ovf | dbl_c[3].ovf;
        fin[13] = |fo_d | n1a_c.ovf | n2a_c.ovf | den1_c.ovf;
        fin[14] = n1b_c.ovf | n2b_c.ovf;
        fin[15] = n1_c.ovf | n2_c.ovf;
        fin[16] = (den_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hold_a_reg[0] <= '{fp_a[3], fp_a[5], fp_a[6], fp_a[8], fp_a[0]};
            for (int k = 1; k < 4; k++) begin
                hold_a_reg[k] <= hold_a_reg[k-1];
            end
            hold_b_reg <= fp_b;
            trig_dly_reg[0] <= '{trig[0], trig[1], trig[3]};
            for (int k = 1; k < 3; k++) begin
                trig_dly_reg[k] <= trig_dly_reg[k-1];
            end
            d4_reg[0] <= d4_c.v;
            for (int k = 1; k <= 9; k++) begin
                d4_reg[k] <= d4_reg[k-1];
            end
            for (int i = 0; i < 4; i++) begin
                dbl_reg[i] <= dbl_c[i].v;
            end
            dbl_dly_reg[0] <= dbl_reg;
            for (int k = 1; k < 3; k++) begin
                dbl_dly_reg[k] <= dbl_dly_reg[k-1];
            end
            tu4_reg[0] <= '{fp_d[1], fp_d[3]};
            tu4_reg[1] <= tu4_reg[0];
            n1a_reg    <= n1a_c.v;
            n2a_reg    <= n2a_c.v;
            den1_reg   <= den1_c.v;
            n1b_reg    <= n1b_c.v;
            n2b_reg    <= n2b_c.v;
            den2_reg   <= den1_reg;
            num_reg[0] <= n1_c.v;
            num_reg[1] <= n2_c.v;
            den_reg    <= den2_reg;
            fl_reg[4]  <= fin[3];
            for (int k = 5; k <= 49; k++) begin
                fl_reg[k] <= fl_reg[k-1] | fin[k-1];
            end
        end
    end

    assign ud_next = den_reg[63] ? 61'(-den_reg) : den_reg[60:0];

    always_ff @(posedge aclk) begin
        if (adv) begin
            ud_reg[0] <= ud_next;
            dz_reg[0] <= (den_reg == '0);
            for (int k = 1; k <= DIV_BITS; k++) begin
                ud_reg[k] <= ud_reg[k-1];
                dz_reg[k] <= dz_reg[k-1];
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_div
        logic [60:0]       un;
        logic [DIV_RW-1:0] sub  [1:DIV_BITS];
        logic              ge   [1:DIV_BITS];
        logic [31:0]       lim;

        always_comb begin
            un = num_reg[l][63] ? 61'(-num_reg[l]) : num_reg[l][60:0];
            for (int j = 1; j <= DIV_BITS; j++) begin
                sub[j] = DIV_RW'(ud_reg[j-1]) << (DIV_BITS - j);
                ge[j]  = r_reg[l][j-1] >= sub[j];
            end
            lim = neg_reg[l][DIV_BITS] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            sat_next[l] = 1'b0;
            if (dz_reg[DIV_BITS]) begin
                acc_next[l] = npos_reg[l][DIV_BITS] ? 32'h7FFF_FFFF :
                              (nneg_reg[l][DIV_BITS] ? 32'h8000_0000 : 32'h0);
            end else if (big_reg[l][DIV_BITS] || q_reg[l][DIV_BITS] > lim) begin
                sat_next[l] = 1'b1;
                acc_next[l] = neg_reg[l][DIV_BITS] ? -lim : lim;
            end else begin
                acc_next[l] = neg_reg[l][DIV_BITS] ? -q_reg[l][DIV_BITS] : q_reg[l][DIV_BITS];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                r_reg[l][0]    <= DIV_RW'(un) << FRAC_BITS;
                q_reg[l][0]    <= '0;
                neg_reg[l][0]  <= num_reg[l][63] ^ den_reg[63];
                big_reg[l][0]  <= DIV_RW'(un) >= (DIV_RW'(ud_next) << (DIV_BITS - FRAC_BITS));
                npos_reg[l][0] <= !num_reg[l][63] && (num_reg[l] != '0);
                nneg_reg[l][0] <= num_reg[l][63];
                for (int j = 1; j <= DIV_BITS; j++) begin
                    r_reg[l][j]    <= ge[j] ? r_reg[l][j-1] - sub[j] : r_reg[l][j-1];
                    q_reg[l][j]    <= q_reg[l][j-1] | (ge[j] ? (32'd1 << (DIV_BITS - j)) : 32'd0);
                    neg_reg[l][j]  <= neg_reg[l][j-1];
                    big_reg[l][j]  <= big_reg[l][j-1];
                    npos_reg[l][j] <= npos_reg[l][j-1];
                    nneg_reg[l][j] <= nneg_reg[l][j-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_w1_reg   <= w_reg[49][0];
            m_w2_reg   <= w_reg[49][1];
            m_acc1_reg <= acc_next[0];
            m_acc2_reg <= acc_next[1];
            m_sat_reg  <= fl_reg[49] | sat_next[0] | sat_next[1];
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        adv && vld_reg[49] |=> m_tvalid)
        else $error("Result lost between the divider and the output register.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[49] && dz_reg[DIV_BITS] |-> fl_reg[49])
        else $error("Zero denominator reached the output without its flag.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[49] && !dz_reg[DIV_BITS] && !big_reg[0][DIV_BITS]
            |-> r_reg[0][DIV_BITS] < DIV_RW'(ud_reg[DIV_BITS]))
        else $error("Divider remainder out of range for the first acceleration.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[49] && !dz_reg[DIV_BITS] && !big_reg[1][DIV_BITS]
            |-> r_reg[1][DIV_BITS] < DIV_RW'(ud_reg[DIV_BITS]))
        else $error("Divider remainder out of range for the second acceleration.");

endmodule

/* verif/compound_double_pendulum_derivative_tb.sv */
// Testbench for the double pendulum derivative pipeline: drives state transfers, predicts
// each derivative with a bit-exact fixed-point model and compares every result transfer.
// Depends on cdpd_pkg and compound_double_pendulum_derivative.
module compound_double_pendulum_derivative_tb;
    import cdpd_pkg::*;

    localparam int  FRAC = 16;
    localparam longint unsigned SAT_MAG = 64'h0FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [31:0] rate_second;
        logic [31:0] angle_second;
        logic [31:0] rate_first;
        logic [31:0] angle_first;
    } pend_state_t;

    typedef struct packed {
        logic        saturated;
        logic [31:0] accel_second;
        logic [31:0] angle_rate_second;
        logic [31:0] accel_first;
        logic [31:0] angle_rate_first;
    } pend_deriv_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_we;
    logic [CFG_AW-1:0] cfg_addr;
    logic [31:0]  cfg_wdata;

    compound_double_pendulum_derivative dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    logic signed [31:0] coef [NUM_REGS];
    pend_deriv_t expected_derivs [$];
    int  send_idle_pct;
    int  recv_stall_pct;
    int  errors;
    longint cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd400000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Magnitude product of two values, shifted and limited; sets sat on overflow.
    function automatic longint signed scaled_mul(longint signed a, longint signed b,
                                                 int sh, ref bit sat);
        logic [127:0] ua, ub, p;
        logic         neg;
        ua = (a < 0) ? 128'(-a) : 128'(a);
        ub = (b < 0) ? 128'(-b) : 128'(b);
        neg = (a < 0) != (b < 0);
        p = (ua * ub) >> sh;
        if (p > 128'(SAT_MAG)) begin
            sat = 1'b1;
            p = 128'(SAT_MAG);
        end
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint signed limit_val(longint signed v, ref bit sat);
        if (v > longint'(SAT_MAG)) begin
            sat = 1'b1;
            return longint'(SAT_MAG);
        end
        if (v < -longint'(SAT_MAG)) begin
            sat = 1'b1;
            return -longint'(SAT_MAG);
        end
        return v;
    endfunction

    function automatic longint signed sine_q2_30(logic [31:0] a);
        logic [63:0] x, x2, p;
        logic [63:0] frac;
        frac = {34'd0, a[29:0]};
        x = a[30] ? (64'h4000_0000 - frac) : frac;
        x2 = (x * x) >> 30;
        p = 64'd172272;
        p = 64'd5026995 - ((x2 * p) >> 30);
        p = 64'd85569306 - ((x2 * p) >> 30);
        p = 64'd693598668 - ((x2 * p) >> 30);
        p = 64'd1686629713 - ((x2 * p) >> 30);
        p = (x * p) >> 30;
        return a[31] ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [31:0] accel_quotient(longint signed n, longint signed d,
                                                   ref bit sat);
        logic [63:0]  un, ud, lim;
        logic [127:0] q;
        logic         neg;
        if (d == 0) begin
            sat = 1'b1;
            return (n > 0) ? 32'h7FFF_FFFF : ((n < 0) ? 32'h8000_0000 : 32'h0);
        end
        un = (n < 0) ? 64'(-n) : 64'(n);
        ud = (d < 0) ? 64'(-d) : 64'(d);
        neg = (n < 0) != (d < 0);
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        q = ({64'd0, un} << FRAC) / {64'd0, ud};
        if (q > {64'd0, lim}) begin
            sat = 1'b1;
            q = {64'd0, lim};
        end
        return neg ? 32'(-q[63:0]) : q[31:0];
    endfunction

    function automatic pend_deriv_t predict_derivative(pend_state_t st);
        pend_deriv_t r;
        bit sat;
        longint signed c0, c1, c2, c3, c4, w1, w2, s1, s2, sd, cd, k22, q1, q2;
        longint signed t1, t2, t3, t4, n1, n2, den;
        logic [31:0] ad;
        sat = 1'b0;
        c0 = coef[0]; c1 = coef[1]; c2 = coef[2]; c3 = coef[3]; c4 = coef[4];
        w1 = signed'(st.rate_first);
        w2 = signed'(st.rate_second);
        ad = st.angle_first - st.angle_second;
        s1 = sine_q2_30(st.angle_first);
        s2 = sine_q2_30(st.angle_second);
        sd = sine_q2_30(ad);
        cd = sine_q2_30(ad + 32'h4000_0000);
        k22 = scaled_mul(c2, c2, FRAC, sat);
        q1 = scaled_mul(w1, w1, FRAC, sat);
        q2 = scaled_mul(w2, w2, FRAC, sat);

        t1 = limit_val(2 * scaled_mul(scaled_mul(c1, c3, FRAC, sat), s1, 30, sat), sat);
        t2 = scaled_mul(scaled_mul(scaled_mul(k22, q1, FRAC, sat), sd, 30, sat), cd, 30, sat);
        t3 = limit_val(2 * scaled_mul(scaled_mul(scaled_mul(c1, c2, FRAC, sat), q2, FRAC, sat),
                                      sd, 30, sat), sat);
        t4 = scaled_mul(scaled_mul(scaled_mul(c2, c4, FRAC, sat), cd, 30, sat), s2, 30, sat);
        n1 = limit_val(limit_val(limit_val(t1 + t2, sat) + t3, sat) - t4, sat);

        t1 = limit_val(2 * scaled_mul(scaled_mul(c0, c4, FRAC, sat), s2, 30, sat), sat);
        t2 = scaled_mul(scaled_mul(scaled_mul(k22, q2, FRAC, sat), sd, 30, sat), cd, 30, sat);
        t3 = limit_val(2 * scaled_mul(scaled_mul(scaled_mul(c0, c2, FRAC, sat), q1, FRAC, sat),
                                      sd, 30, sat), sat);
        t4 = scaled_mul(scaled_mul(scaled_mul(c2, c3, FRAC, sat), cd, 30, sat), s1, 30, sat);
        n2 = limit_val(limit_val(limit_val(t1 - t2, sat) - t3, sat) - t4, sat);

        den = limit_val(scaled_mul(scaled_mul(k22, cd, 30, sat), cd, 30, sat)
                        - limit_val(4 * scaled_mul(c0, c1, FRAC, sat), sat), sat);

        r.angle_rate_first  = st.rate_first;
        r.angle_rate_second = st.rate_second;
        r.accel_first       = accel_quotient(n1, den, sat);
        r.accel_second      = accel_quotient(n2, den, sat);
        r.saturated         = sat;
        return r;
    endfunction

    // Result checker: compares each result transfer with the oldest prediction.
    always @(posedge aclk) begin
        pend_deriv_t got, exp_d;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata};
            if (expected_derivs.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
            end else begin
                exp_d = expected_derivs.pop_front();
                if (got.angle_rate_first !== exp_d.angle_rate_first)
                    $display("%0t: angle_rate_first expected %h actual %h", $time,
                             exp_d.angle_rate_first, got.angle_rate_first);
                if (got.accel_first !== exp_d.accel_first)
                    $display("%0t: accel_first expected %h actual %h", $time,
                             exp_d.accel_first, got.accel_first);
                if (got.angle_rate_second !== exp_d.angle_rate_second)
                    $display("%0t: angle_rate_second expected %h actual %h", $time,
                             exp_d.angle_rate_second, got.angle_rate_second);
                if (got.accel_second !== exp_d.accel_second)
                    $display("%0t: accel_second expected %h actual %h", $time,
                             exp_d.accel_second, got.accel_second);
                if (got.saturated !== exp_d.saturated)
                    $display("%0t: saturated expected %b actual %b", $time,
                             exp_d.saturated, got.saturated);
                if (got !== exp_d)
                    errors++;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // The valid line stays high between back-to-back transfers; idle cycles drop it.
    task automatic send_state(pend_state_t st);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= st;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_derivs.push_back(predict_derivative(st));
        @(negedge aclk);
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (expected_derivs.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic write_coef(logic [CFG_AW-1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx < NUM_REGS)
            coef[idx] = val;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_word(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($urandom_range(8 * 65536)) - 32'(4 * 65536);
            2: return {$urandom_range(3) == 0, 31'($urandom_range(3))};
            default: return 32'($urandom_range(2 * 65536)) - 32'(65536);
        endcase
    endfunction

    function automatic pend_state_t rand_state();
        pend_state_t st;
        st.angle_first  = $urandom();
        st.angle_second = ($urandom_range(7) == 0) ? st.angle_first : $urandom();
        st.rate_first   = rand_word($urandom_range(3));
        st.rate_second  = rand_word($urandom_range(3));
        return st;
    endfunction

    task automatic test_directed_extremes();
        logic [31:0] vals [6] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'h4000_0000, 32'hC000_0000};
        for (int i = 0; i < 6; i++)
            send_state({vals[i], vals[(i + 1) % 6], vals[(i + 2) % 6], vals[(i + 3) % 6]});
        send_state({32'h0001_0000, 32'h2000_0000, 32'hFFFF_0000, 32'h2000_0000});
        drain_pipeline();
    endtask

    task automatic test_zero_denominator();
        // With coupling and first inertia at zero the shared denominator vanishes.
        write_coef(REG_COUPLING, 32'h0);
        write_coef(REG_INERTIA_FIRST, 32'h0);
        send_state({32'h0, 32'h0, 32'h0, 32'h0});
        send_state({32'h0001_0000, 32'h1000_0000, 32'h0002_0000, 32'h3000_0000});
        send_state({32'hFFFF_0000, 32'hD000_0000, 32'h0001_0000, 32'h5000_0000});
        drain_pipeline();
    endtask

    task automatic test_unknown_register();
        write_coef(3'd5, 32'hDEAD_BEEF);
        write_coef(3'd7, 32'h1234_5678);
        write_coef(REG_INERTIA_FIRST, 32'h0001_0000);
        write_coef(REG_COUPLING, 32'h0000_8000);
        send_state({32'h0000_8000, 32'h1234_5678, 32'hFFFF_8000, 32'h8765_4321});
        drain_pipeline();
    endtask

    task automatic test_coef_setting(logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                                     logic [31:0] c3, logic [31:0] c4, int count);
        write_coef(REG_INERTIA_FIRST, c0);
        write_coef(REG_INERTIA_SECOND, c1);
        write_coef(REG_COUPLING, c2);
        write_coef(REG_GRAVITY_FIRST, c3);
        write_coef(REG_GRAVITY_SECOND, c4);
        for (int i = 0; i < count; i++) begin
            if (i == count / 4) begin
                send_idle_pct = 48; recv_stall_pct = 0;
            end else if (i == count / 2) begin
                send_idle_pct = 0; recv_stall_pct = 48;
            end else if (i == 3 * count / 4) begin
                send_idle_pct = 13; recv_stall_pct = 13;
            end else if (i == 0) begin
                send_idle_pct = 0; recv_stall_pct = 0;
            end
            send_state(rand_state());
        end
        drain_pipeline();
        send_idle_pct = 0; recv_stall_pct = 0;
    endtask

    task automatic test_random_settings();
        test_coef_setting(32'h0001_0000, 32'h0001_0000, 32'h0000_8000,
                          32'h0001_0000, 32'h0001_0000, 160);
        test_coef_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h7FFF_FFFF, 60);
        test_coef_setting(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
                          32'h0000_0001, 32'hFFFF_FFFF, 60);
        test_coef_setting($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 60);
        test_coef_setting(rand_word(3), rand_word(3), rand_word(1), rand_word(1),
                          rand_word(3), 160);
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        coef[0] = INERTIA_FIRST_RST;
        coef[1] = INERTIA_SECOND_RST;
        coef[2] = COUPLING_RST;
        coef[3] = GRAVITY_FIRST_RST;
        coef[4] = GRAVITY_SECOND_RST;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_extremes();
        test_zero_denominator();
        test_unknown_register();
        test_random_settings();

        if (errors == 0 && expected_derivs.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
